// ===== design/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg - shared definitions for the static linked list engine
// Field widths, request kinds and status codes used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package sll_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ===== design/static_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit - linked list in a fixed node store
// Command-driven engine that inserts, deletes, reads and locates values in a
// singly linked list held in two synchronous memories.
//
// Raise start with kind, position and value while busy is low; that edge is
// the transfer of the request. Exactly one result follows, shown for a single
// cycle with done high; the receiver must take it then, since the block never
// holds a result back. A request that walks the list follows one link per
// cycle through the registered read port of the link memory, so the cost
// grows with the position: a rejected request, an insert at the head and a
// locate on an empty list answer in the cycle after the transfer, while a
// read, a delete further down, an insert further down and a locate first
// step through the list node by node.
// A new node always takes the highest-numbered free slot; a position past
// the end of the list on insert appends at the tail. list_length on a result
// is the node count after that request.
// ----------------------------------------------------------------------------
`default_nettype none

module static_linked_list_engine_unit #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic        [sll_pkg::KIND_W-1:0]  kind,
    input  wire logic        [sll_pkg::POS_W-1:0]   position,
    input  wire logic signed [sll_pkg::VAL_W-1:0]   value,
    output logic                                    busy,
    output logic                                    done,
    output logic             [sll_pkg::STAT_W-1:0]  status,
    output logic signed      [sll_pkg::VAL_W-1:0]   result_value,
    output logic             [sll_pkg::POS_W-1:0]   found_position,
    output logic             [sll_pkg::POS_W-1:0]   list_length
);

    import sll_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;   // follow links toward the target
    localparam logic [3:0] S_LOC  = 4'd2;   // compare values node by node
    localparam logic [3:0] S_RDV  = 4'd3;   // read data of target ready
    localparam logic [3:0] S_DLQ  = 4'd4;   // link of predecessor ready
    localparam logic [3:0] S_DLF  = 4'd5;   // victim data ready, unlink it
    localparam logic [3:0] S_DLH  = 4'd6;   // head data ready, drop head
    localparam logic [3:0] S_INS  = 4'd7;   // write link of new node
    localparam logic [3:0] S_INS2 = 4'd8;   // splice new node after predecessor

    // Control state
    logic [3:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;

    // Per-request working and result registers
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [AW-1:0]     slot_reg, slot_next;     // walk origin, then target (predecessor on insert/delete)
    logic              first_reg, first_next;
    logic [AW-1:0]     hops_reg, hops_next;
    logic [AW-1:0]     node_reg, node_next;     // new node or victim slot
    logic [CW-1:0]     idx_reg, idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] rval_reg, rval_next;
    logic [CW-1:0]     fpos_reg, fpos_next;

    // Store and allocator hookup
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_value;
    logic [AW-1:0]     rd_link;
    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [DATA_W-1:0] val_wdata;
    logic              lnk_we;
    logic [AW-1:0]     lnk_waddr;
    logic [AW-1:0]     lnk_wdata;
    logic              take_en;
    logic              give_en;
    logic [AW-1:0]     give_slot;
    logic [AW-1:0]     top_slot;

    logic              accept;
    logic [DATA_W-1:0] vin;
    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   cnt_ext;
    logic [CMPW-1:0]   pos_m1;
    logic [CMPW-1:0]   prev_pos;
    logic              pos_bad;
    logic [AW-1:0]     cur;

    assign accept  = start && !busy;
    assign vin     = DATA_W'($unsigned(value));
    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count_reg);
    assign pos_m1  = pos_ext - CMPW'(1);
    // Clamp insert positions past the end to the tail
    assign prev_pos = (pos_m1 > cnt_ext) ? cnt_ext : pos_m1;
    assign pos_bad  = (position == '0) || (pos_ext > cnt_ext);

    // Current node of a walk: the origin first, then the link just read
    assign cur = first_reg ? slot_reg : rd_link;

    sll_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_value  (rd_value),
        .rd_link   (rd_link),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .lnk_we    (lnk_we),
        .lnk_waddr (lnk_waddr),
        .lnk_wdata (lnk_wdata)
    );

    sll_alloc #(
        .DEPTH (DEPTH)
    ) u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .take_en   (take_en),
        .take_slot (top_slot),
        .give_en   (give_en),
        .give_slot (give_slot),
        .top_slot  (top_slot)
    );

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        head_next   = head_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        slot_next   = slot_reg;
        first_next  = first_reg;
        hops_next   = hops_reg;
        node_next   = node_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        fpos_next   = fpos_reg;

        rd_en     = 1'b0;
        rd_addr   = cur;
        val_we    = 1'b0;
        val_waddr = top_slot;
        val_wdata = vin;
        lnk_we    = 1'b0;
        lnk_waddr = node_reg;
        lnk_wdata = rd_link;
        take_en   = 1'b0;
        give_en   = 1'b0;
        give_slot = node_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = kind;
                    val_next    = vin;
                    status_next = ST_OK;
                    rval_next   = '0;
                    fpos_next   = '0;
                    slot_next   = head_reg;
                    first_next  = 1'b1;
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (position == '0)
                            begin
                                status_next = ST_BADPOS;
                                done_next   = 1'b1;
                            end
                            else if (count_reg >= CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // Claim the slot and store the value right away
                                val_we     = 1'b1;
                                take_en    = 1'b1;
                                node_next  = top_slot;
                                count_next = count_reg + CW'(1);
                                if (position == POS_W'(1) || count_reg == '0)
                                begin
                                    lnk_we    = 1'b1;
                                    lnk_waddr = top_slot;
                                    lnk_wdata = head_reg;
                                    head_next = top_slot;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    hops_next  = AW'(prev_pos - CMPW'(1));
                                    state_next = S_WALK;
                                end
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (pos_bad)
                            begin
                                status_next = ST_BADPOS;
                                done_next   = 1'b1;
                            end
                            else if (position == POS_W'(1))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                node_next  = head_reg;
                                state_next = S_DLH;
                            end
                            else
                            begin
                                hops_next  = AW'(pos_ext - CMPW'(2));
                                state_next = S_WALK;
                            end
                        end
                        KIND_READ:
                        begin
                            if (pos_bad)
                            begin
                                status_next = ST_BADPOS;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                hops_next  = AW'(pos_m1);
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                idx_next   = CW'(1);
                                state_next = S_LOC;
                            end
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // One link per cycle; the read at the target also fetches its data
                rd_en      = 1'b1;
                rd_addr    = cur;
                first_next = 1'b0;
                if (hops_reg == '0)
                begin
                    slot_next = cur;
                    case (kind_reg)
                        KIND_INSERT: state_next = S_INS;
                        KIND_DELETE: state_next = S_DLQ;
                        default:     state_next = S_RDV;
                    endcase
                end
                else
                begin
                    hops_next = hops_reg - AW'(1);
                end
            end

            S_INS:
            begin
                // New node inherits the predecessor's successor
                lnk_we     = 1'b1;
                lnk_waddr  = node_reg;
                lnk_wdata  = rd_link;
                state_next = S_INS2;
            end

            S_INS2:
            begin
                lnk_we     = 1'b1;
                lnk_waddr  = slot_reg;
                lnk_wdata  = node_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RDV:
            begin
                rval_next  = rd_value;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DLQ:
            begin
                // Victim is the predecessor's successor; fetch it
                node_next  = rd_link;
                rd_en      = 1'b1;
                rd_addr    = rd_link;
                state_next = S_DLF;
            end

            S_DLF:
            begin
                lnk_we     = 1'b1;
                lnk_waddr  = slot_reg;
                lnk_wdata  = rd_link;
                rval_next  = rd_value;
                give_en    = 1'b1;
                give_slot  = node_reg;
                count_next = count_reg - CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DLH:
            begin
                // Drop the head; an emptied list parks the head at slot zero
                head_next  = (count_reg == CW'(1)) ? '0 : rd_link;
                rval_next  = rd_value;
                give_en    = 1'b1;
                give_slot  = node_reg;
                count_next = count_reg - CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_LOC:
            begin
                if (rd_value == val_reg)
                begin
                    fpos_next  = idx_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_reg == count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_link;
                    idx_next = idx_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        first_reg  <= first_next;
        hops_reg   <= hops_next;
        node_reg   <= node_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        fpos_reg   <= fpos_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign result_value   = VAL_W'($unsigned(rval_reg));
    assign found_position = POS_W'(fpos_reg);
    assign list_length    = POS_W'(count_reg);

endmodule

`default_nettype wire

// ===== design/sll_store.sv =====
// ----------------------------------------------------------------------------
// sll_store - node store
// Value and link memories; one shared registered read port, one write port
// on each memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_value,
    output logic      [$clog2(DEPTH)-1:0]   rd_link,
    input  wire logic                       val_we,
    input  wire logic [$clog2(DEPTH)-1:0]   val_waddr,
    input  wire logic [DATA_W-1:0]          val_wdata,
    input  wire logic                       lnk_we,
    input  wire logic [$clog2(DEPTH)-1:0]   lnk_waddr,
    input  wire logic [$clog2(DEPTH)-1:0]   lnk_wdata
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] val_mem [DEPTH];
    logic [AW-1:0]     lnk_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_value <= val_mem[rd_addr];
            rd_link  <= lnk_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sll_alloc.sv =====
// ----------------------------------------------------------------------------
// sll_alloc - slot allocator
// Free mark per slot; offers the highest-numbered free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_alloc #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take_en,
    input  wire logic [$clog2(DEPTH)-1:0]   take_slot,
    input  wire logic                       give_en,
    input  wire logic [$clog2(DEPTH)-1:0]   give_slot,
    output logic      [$clog2(DEPTH)-1:0]   top_slot
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0] free_reg;
    logic [DEPTH-1:0] free_next;

    always_comb
    begin
        free_next = free_reg;
        if (take_en)
        begin
            free_next[take_slot] = 1'b0;
        end
        if (give_en)
        begin
            free_next[give_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

    // Highest free slot wins
    always_comb
    begin
        top_slot = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (free_reg[k])
            begin
                top_slot = AW'(k);
            end
        end
    end

endmodule

`default_nettype wire
